// ----- rtl/dbpk_pkg.sv -----
// Shared types, constants and the base decoder for the DNA base packer.
`timescale 1ns / 1ps

package dbpk_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned KLEN_W  = 5;
    localparam int unsigned KMAX    = 16;
    localparam int unsigned PLANE_W = 27;
    localparam int unsigned PAIR_W  = 28;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd12;

    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UC = 8'h43;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_UT = 8'h54;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LC = 8'h63;
    localparam logic [7:0] CH_LG = 8'h67;
    localparam logic [7:0] CH_LT = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // One decoded beat as seen by the k-mer and packing units.
    typedef struct packed {
        logic       flush;
        logic       is_n;
        logic [1:0] code;
    } t_base;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  start;
    } t_kmer_res;

    typedef struct packed {
        logic               plane_valid;
        logic [PLANE_W-1:0] plane_index;
        logic [WORD_W-1:0]  low_plane;
        logic [WORD_W-1:0]  high_plane;
        logic [WORD_W-1:0]  n_mask;
        logic               pair_valid;
        logic [PAIR_W-1:0]  pair_index;
        logic [WORD_W-1:0]  pair_word;
    } t_pack_res;

    function automatic t_base decode_base(input logic [7:0] ch, input logic flush);
        t_base b;
        b.flush = flush;
        b.is_n  = 1'b0;
        b.code  = CODE_A;
        case (ch)
            CH_UA, CH_LA: b.code = CODE_A;
            CH_UC, CH_LC: b.code = CODE_C;
            CH_UG, CH_LG: b.code = CODE_G;
            CH_UT, CH_LT: b.code = CODE_T;
            default:      b.is_n = 1'b1;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/dbpk_kmer.sv -----
// Rolling k-mer register, run counter and sampled k-mer detection.
`timescale 1ns / 1ps

module dbpk_kmer #(
    parameter int unsigned SAMPLE_STEP = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  dbpk_pkg::t_base           i_base,
    input  logic [dbpk_pkg::POS_W-1:0]  i_pos,
    input  logic [dbpk_pkg::KLEN_W-1:0] i_k,
    output dbpk_pkg::t_kmer_res       o_res
);
    import dbpk_pkg::*;

    localparam int unsigned RES_W = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
    localparam int unsigned SUM_W = RES_W + 2;
    localparam logic [SUM_W-1:0] STEP = SUM_W'(SAMPLE_STEP);
    // residue of 2^32, used when the start position wraps below zero
    localparam logic [SUM_W-1:0] WRAP_RES = SUM_W'(64'h1_0000_0000 % SAMPLE_STEP);

    logic [WORD_W-1:0] r_kmer;
    logic [KLEN_W-1:0] r_run;
    logic [RES_W-1:0]  r_res;      // position mod SAMPLE_STEP

    logic [WORD_W-1:0] n_kmer;
    logic [KLEN_W-1:0] n_run;
    logic [RES_W-1:0]  n_res;

    logic [2*KLEN_W-1:0] two_k;
    logic [WORD_W:0]     mask_ext;
    logic [WORD_W-1:0]   kmask;
    logic [WORD_W-1:0]   shifted;
    logic [KLEN_W:0]     run_inc;
    logic                full;
    logic [POS_W-1:0]    next_pos;
    logic [POS_W-1:0]    start;
    logic                wrap;
    logic [RES_W-1:0]    k_res;
    logic [SUM_W-1:0]    sum0;
    logic [SUM_W-1:0]    sum1;
    logic [SUM_W-1:0]    sum2;

    always_comb begin
        k_res = '0;
        for (int i = 0; i <= KMAX; i++) begin
            if (i_k == KLEN_W'(i)) begin
                k_res = RES_W'(i % SAMPLE_STEP);
            end
        end
    end

    always_comb begin
        two_k    = {5'd0, i_k} << 1;
        mask_ext = (33'd1 << two_k) - 33'd1;
        kmask    = mask_ext[WORD_W-1:0];
        shifted  = WORD_W'(i_base.code) << (two_k - 10'd2);
        run_inc  = {1'b0, r_run} + 6'd1;
        full     = (run_inc >= {1'b0, i_k});
        next_pos = i_pos + 32'd1;
        start    = next_pos - POS_W'(i_k);
        wrap     = (next_pos < POS_W'(i_k));

        // residue of the next position; the counter restarts when the position wraps
        if (i_pos == '1 || r_res == RES_W'(SAMPLE_STEP - 1)) begin
            n_res = '0;
        end else begin
            n_res = r_res + RES_W'(1);
        end

        sum0 = SUM_W'(n_res) + STEP - SUM_W'(k_res) + (wrap ? WRAP_RES : '0);
        sum1 = (sum0 >= STEP) ? sum0 - STEP : sum0;
        sum2 = (sum1 >= STEP) ? sum1 - STEP : sum1;

        n_kmer = r_kmer;
        n_run  = r_run;
        o_res  = '0;
        if (i_base.is_n) begin
            n_kmer = '0;
            n_run  = '0;
        end else begin
            n_kmer = ((r_kmer >> 2) | shifted) & kmask;
            if (full) begin
                n_run = i_k - KLEN_W'(1);
                if (sum2 == '0) begin
                    o_res.valid = 1'b1;
                    o_res.value = n_kmer;
                    o_res.start = start;
                end
            end else begin
                n_run = run_inc[KLEN_W-1:0];
            end
        end
        if (i_base.flush) begin
            o_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer <= '0;
            r_run  <= '0;
            r_res  <= '0;
        end else if (i_adv && !i_base.flush) begin
            r_kmer <= n_kmer;
            r_run  <= n_run;
            r_res  <= n_res;
        end
    end

endmodule

// ----- rtl/dbpk_pack.sv -----
// Bit-plane and 2-bit pair packers with group-complete and flush reporting.
`timescale 1ns / 1ps

module dbpk_pack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  dbpk_pkg::t_base            i_base,
    input  logic [dbpk_pkg::POS_W-1:0] i_pos,
    output dbpk_pkg::t_pack_res        o_res
);
    import dbpk_pkg::*;

    logic [WORD_W-1:0] r_low;
    logic [WORD_W-1:0] r_high;
    logic [WORD_W-1:0] r_nacc;
    logic [WORD_W-1:0] r_pair;

    logic [WORD_W-1:0] n_low;
    logic [WORD_W-1:0] n_high;
    logic [WORD_W-1:0] n_nacc;
    logic [WORD_W-1:0] n_pair;

    logic [WORD_W-1:0] low_upd;
    logic [WORD_W-1:0] high_upd;
    logic [WORD_W-1:0] nacc_upd;
    logic [WORD_W-1:0] pair_upd;
    logic              plane_end;
    logic              pair_end;

    always_comb begin
        low_upd   = r_low  | (WORD_W'(i_base.code[0]) << i_pos[4:0]);
        high_upd  = r_high | (WORD_W'(i_base.code[1]) << i_pos[4:0]);
        nacc_upd  = r_nacc | (WORD_W'(i_base.is_n) << i_pos[4:0]);
        pair_upd  = r_pair | (WORD_W'(i_base.code) << {i_pos[3:0], 1'b0});
        plane_end = (i_pos[4:0] == 5'h1f);
        pair_end  = (i_pos[3:0] == 4'hf);

        o_res  = '0;
        n_low  = plane_end ? '0 : low_upd;
        n_high = plane_end ? '0 : high_upd;
        n_nacc = plane_end ? '0 : nacc_upd;
        n_pair = pair_end  ? '0 : pair_upd;

        if (i_base.flush) begin
            // partial words, only when the group has at least one base
            if (i_pos[4:0] != 5'd0) begin
                o_res.plane_valid = 1'b1;
                o_res.plane_index = i_pos[POS_W-1:5];
                o_res.low_plane   = r_low;
                o_res.high_plane  = r_high;
                o_res.n_mask      = r_nacc;
            end
            if (i_pos[3:0] != 4'd0) begin
                o_res.pair_valid = 1'b1;
                o_res.pair_index = i_pos[POS_W-1:4];
                o_res.pair_word  = r_pair;
            end
        end else begin
            if (plane_end) begin
                o_res.plane_valid = 1'b1;
                o_res.plane_index = i_pos[POS_W-1:5];
                o_res.low_plane   = low_upd;
                o_res.high_plane  = high_upd;
                o_res.n_mask      = nacc_upd;
            end
            if (pair_end) begin
                o_res.pair_valid = 1'b1;
                o_res.pair_index = i_pos[POS_W-1:4];
                o_res.pair_word  = pair_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_nacc <= '0;
            r_pair <= '0;
        end else if (i_adv && !i_base.flush) begin
            r_low  <= n_low;
            r_high <= n_high;
            r_nacc <= n_nacc;
            r_pair <= n_pair;
        end
    end

endmodule

// ----- rtl/dna_base_packer_kmer_extractor.sv -----
// Top level: input register, position counter, k-mer and packing units, result register.
`timescale 1ns / 1ps

// One reference character per input beat, one result beat per input beat. Throughput
// is one beat per clock with no bubbles while i_out_stall is low; an accepted beat passes
// through the input register, then the k-mer and packing logic into the result
// register. Stall on the result side propagates to o_in_stall in the same cycle.
// k (kmer_length) must only be written while no beat is in flight; 0 acts as 1 and
// values above 16 act as 16. The base position wraps at 2^32 and the sampling test
// uses the wrapped start position. A flush beat changes no k-mer, pack or position state.
module dna_base_packer_kmer_extractor #(
    parameter int unsigned SAMPLE_STEP = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dbpk_pkg::KLEN_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_base_char,
    input  logic                         i_flush,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_kmer_valid,
    output logic [dbpk_pkg::WORD_W-1:0]  o_kmer_value,
    output logic [dbpk_pkg::POS_W-1:0]   o_kmer_start,
    output logic                         o_plane_valid,
    output logic [dbpk_pkg::PLANE_W-1:0] o_plane_index,
    output logic [dbpk_pkg::WORD_W-1:0]  o_low_plane,
    output logic [dbpk_pkg::WORD_W-1:0]  o_high_plane,
    output logic [dbpk_pkg::WORD_W-1:0]  o_n_mask,
    output logic                         o_pair_valid,
    output logic [dbpk_pkg::PAIR_W-1:0]  o_pair_index,
    output logic [dbpk_pkg::WORD_W-1:0]  o_pair_word
);
    import dbpk_pkg::*;

    logic [KLEN_W-1:0] r_kmer_length;
    logic              r_in_valid;
    logic [7:0]        r_char;
    logic              r_flush;
    logic [POS_W-1:0]  r_pos;
    logic              r_out_valid;
    t_kmer_res         r_kmer_res;
    t_pack_res         r_pack_res;

    logic              out_adv;
    logic              move;
    logic              in_acc;
    logic [KLEN_W-1:0] eff_k;
    t_base             base;
    t_kmer_res         kmer_res;
    t_pack_res         pack_res;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign base       = decode_base(r_char, r_flush);

    always_comb begin
        if (r_kmer_length == '0) begin
            eff_k = KLEN_W'(1);
        end else if (r_kmer_length > KLEN_W'(KMAX)) begin
            eff_k = KLEN_W'(KMAX);
        end else begin
            eff_k = r_kmer_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= KLEN_RESET;
        end else if (i_cfg_we) begin
            r_kmer_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_char  <= i_base_char;
            r_flush <= i_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (move && !r_flush) begin
            r_pos <= r_pos + 32'd1;
        end
    end

    dbpk_kmer #(
        .SAMPLE_STEP (SAMPLE_STEP)
    ) u_kmer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (move),
        .i_base  (base),
        .i_pos   (r_pos),
        .i_k     (eff_k),
        .o_res   (kmer_res)
    );

    dbpk_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (move),
        .i_base  (base),
        .i_pos   (r_pos),
        .o_res   (pack_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_kmer_res <= kmer_res;
            r_pack_res <= pack_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kmer_valid  = r_kmer_res.valid;
    assign o_kmer_value  = r_kmer_res.value;
    assign o_kmer_start  = r_kmer_res.start;
    assign o_plane_valid = r_pack_res.plane_valid;
    assign o_plane_index = r_pack_res.plane_index;
    assign o_low_plane   = r_pack_res.low_plane;
    assign o_high_plane  = r_pack_res.high_plane;
    assign o_n_mask      = r_pack_res.n_mask;
    assign o_pair_valid  = r_pack_res.pair_valid;
    assign o_pair_index  = r_pack_res.pair_index;
    assign o_pair_word   = r_pack_res.pair_word;

endmodule

// ----- rtl/dbpk_checker.sv -----
// Port-level assertions for the base packer, bound to the top level.
`timescale 1ns / 1ps

module dbpk_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_kmer_valid,
    input logic [dbpk_pkg::WORD_W-1:0]  o_kmer_value,
    input logic [dbpk_pkg::POS_W-1:0]   o_kmer_start,
    input logic                         o_plane_valid,
    input logic [dbpk_pkg::PLANE_W-1:0] o_plane_index,
    input logic [dbpk_pkg::WORD_W-1:0]  o_low_plane,
    input logic [dbpk_pkg::WORD_W-1:0]  o_high_plane,
    input logic [dbpk_pkg::WORD_W-1:0]  o_n_mask,
    input logic                         o_pair_valid,
    input logic [dbpk_pkg::PAIR_W-1:0]  o_pair_index,
    input logic [dbpk_pkg::WORD_W-1:0]  o_pair_word
);

    // a beat without a sampled k-mer carries zero k-mer fields
    a_kmer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_kmer_valid) |-> (o_kmer_value == '0 && o_kmer_start == '0))
        else $error("k-mer fields nonzero without kmer_valid");

    a_plane_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_plane_valid) |->
            (o_plane_index == '0 && o_low_plane == '0 && o_high_plane == '0
             && o_n_mask == '0))
        else $error("plane fields nonzero without plane_valid");

    // both words come from the same position, so the group indexes line up
    a_index_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_plane_valid && o_pair_valid) |->
            (o_plane_index == o_pair_index[dbpk_pkg::PAIR_W-1:1]))
        else $error("plane and pair group indexes disagree");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_kmer_value) && $stable(o_pair_word)))
        else $error("stalled result beat changed");

endmodule

bind dna_base_packer_kmer_extractor dbpk_checker u_dbpk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kmer_valid  (o_kmer_valid),
    .o_kmer_value  (o_kmer_value),
    .o_kmer_start  (o_kmer_start),
    .o_plane_valid (o_plane_valid),
    .o_plane_index (o_plane_index),
    .o_low_plane   (o_low_plane),
    .o_high_plane  (o_high_plane),
    .o_n_mask      (o_n_mask),
    .o_pair_valid  (o_pair_valid),
    .o_pair_index  (o_pair_index),
    .o_pair_word   (o_pair_word)
);
